// ----- rtl/core/dpq_pkg.sv -----
package dpq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// request codes
	localparam logic OP_ENQUEUE = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// response status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_DEQUEUED  = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic        opcode;
		logic [15:0] proc_id;
		logic [31:0] name_tag;
		logic [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_id;
		logic [31:0] out_name;
		logic [7:0]  out_priority;
		logic [4:0]  occupancy;
	} rsp_t;

	// one queued entry
	typedef struct packed {
		logic [15:0] id;
		logic [31:0] name;
		logic [7:0]  prio;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic   ins;
		logic   deq;
		entry_t ent;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/dpq_cell.sv -----
module dpq_cell import dpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       left_valid,
	input  logic       left_behind,
	input  entry_t     left_ent,
	input  logic       right_valid,
	input  entry_t     right_ent,
	output logic       cell_valid,
	output entry_t     cell_ent,
	output logic       behind,
	output logic       match
);

	logic   valid_q;
	entry_t ent_q;

	// new entry lands at or ahead of this cell when this slot is free or holds a larger value
	assign behind     = !valid_q || (ent_q.prio > ctrl.ent.prio);
	assign match      = valid_q && (ent_q.id == ctrl.ent.id);
	assign cell_valid = valid_q;
	assign cell_ent   = ent_q;

	// occupancy bit: grow from the left on insert, shrink from the right on dequeue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q || left_valid;
		end else if (ctrl.deq) begin
			valid_q <= right_valid;
		end
	end

	// payload: hold, take the left neighbor, take the new entry, or take the right neighbor
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (behind) begin
				ent_q <= left_behind ? left_ent : ctrl.ent;
			end
		end else if (ctrl.deq) begin
			ent_q <= right_ent;
		end
	end

endmodule

// ----- rtl/core/dedup_priority_queue_core.sv -----
// Deduplicating priority queue of process entries (id, name tag, priority).
// Request channel req_valid/req_ready/req carries an enqueue or a dequeue.
// Response channel rsp_valid/rsp_ready/rsp returns exactly one status word
// per request, in request order.
// Entries live in a row of cells sorted by ascending priority, head in cell 0.
// Every cell compares its entry with the request in the same cycle and
// shifts toward its neighbor.
// Latency: the response is valid the cycle after the request transfer.
// Throughput: one request per cycle while the response side keeps up; the
// single response register is the only buffer.
// A stalled response (rsp_valid high, rsp_ready low) holds req_ready low
// until the response transfers.
// Reset empties the queue and drops any pending response.
module dedup_priority_queue_core import dpq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [QUEUE_DEPTH-1:0] valid_v;
	logic [QUEUE_DEPTH-1:0] behind_v;
	logic [QUEUE_DEPTH-1:0] match_v;
	entry_t                 ent_v [QUEUE_DEPTH];
	logic [CNT_W-1:0]       count_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	logic                   fire;
	logic                   dup;
	logic                   full;
	logic                   empty;
	cell_ctrl_t             ctrl;
	rsp_t                   rsp_next;
	logic [CNT_W-1:0]       count_next;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign fire      = req_valid && req_ready;
	assign dup       = |match_v;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	// broadcast command to the cell row
	always_comb begin
		ctrl.ent.id   = req.proc_id;
		ctrl.ent.name = req.name_tag;
		ctrl.ent.prio = req.priority_req;
		ctrl.ins      = fire && (req.opcode == OP_ENQUEUE) && !dup && !full;
		ctrl.deq      = fire && (req.opcode == OP_DEQUEUE) && !empty;
	end

	// cell row
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		logic   lv, lb, rv;
		entry_t le, re;
		if (k == 0) begin : g_head
			assign lv = 1'b1;
			assign lb = 1'b0;
			assign le = '0;
		end else begin : g_mid
			assign lv = valid_v[k-1];
			assign lb = behind_v[k-1];
			assign le = ent_v[k-1];
		end
		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign rv = 1'b0;
			assign re = '0;
		end else begin : g_body
			assign rv = valid_v[k+1];
			assign re = ent_v[k+1];
		end
		dpq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_valid  (lv),
			.left_behind (lb),
			.left_ent    (le),
			.right_valid (rv),
			.right_ent   (re),
			.cell_valid  (valid_v[k]),
			.cell_ent    (ent_v[k]),
			.behind      (behind_v[k]),
			.match       (match_v[k])
		);
	end

	// next count and response word
	always_comb begin
		count_next = count_q;
		if (ctrl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctrl.deq) begin
			count_next = count_q - CNT_W'(1);
		end
		rsp_next = '0;
		if (req.opcode == OP_DEQUEUE) begin
			if (empty) begin
				rsp_next.status = ST_EMPTY;
			end else begin
				rsp_next.status       = ST_DEQUEUED;
				rsp_next.out_id       = ent_v[0].id;
				rsp_next.out_name     = ent_v[0].name;
				rsp_next.out_priority = ent_v[0].prio;
			end
		end else if (dup) begin
			rsp_next.status = ST_DUPLICATE;
		end else if (full) begin
			rsp_next.status = ST_FULL;
		end else begin
			rsp_next.status = ST_INSERTED;
		end
		rsp_next.occupancy = 5'(count_next);
	end

	// count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q <= count_next;
			end
			rsp_valid_q <= fire || (rsp_valid_q && !rsp_ready);
		end
	end

	// load response payload on transfer
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/dpq_checker.sv -----
module dpq_checker import dpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// every request transfer yields a response next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("response missing after request transfer");

	// a stalled response blocks new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

	// only a dequeue carries entry data, and an empty answer leaves nothing queued
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DEQUEUED) |->
		rsp.out_id == '0 && rsp.out_name == '0 && rsp.out_priority == '0 &&
		(rsp.status != ST_EMPTY || rsp.occupancy == '0))
		else $error("data fields set on non-dequeue response");

endmodule

bind dedup_priority_queue_core dpq_checker u_dpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
